/* sv/bme_pkg.sv */
package bme_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam logic [5:0]  GroupsPerLineReset = 6'd19;

  localparam logic [7:0] CharPad = 8'h3D;  // '='
  localparam logic [7:0] CharCr  = 8'h0D;
  localparam logic [7:0] CharLf  = 8'h0A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       end_of_text;
  } out_item_t;

  // Characters produced by one input byte, emitted in order 0..last_idx.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            eot;
  } job_t;

  typedef enum logic [2:0] {
    PH_0 = 3'b001,
    PH_1 = 3'b010,
    PH_2 = 3'b100
  } phase_e;

  // Standard alphabet lookup.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    case (v) inside
      [6'd0:6'd25]:  r = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: r = 8'h61 + {2'b00, v} - 8'd26;
      [6'd52:6'd61]: r = 8'h30 + {2'b00, v} - 8'd52;
      6'd62:         r = 8'h2B;
      default:       r = 8'h2F;
    endcase
    return r;
  endfunction

endpackage

/* sv/base64_mime_encoder_unit.sv */
// Channel    Direction  Handshake                 Payload
// input      in         in_valid_i / in_ready_o   in_item_i  (data_byte, final_byte)
// output     out        out_valid_o / out_ready_i out_item_o (out_char, end_of_text)
// config     in         cfg_we_i (no wait)        cfg_wdata_i (groups_per_line)
//
// Each byte yields one to four characters; the output register emits one
// character per cycle while out_ready_i is high (about 4/3 characters per
// byte in steady state, plus 2 per line break).
// The front end takes one byte per cycle while the job queue has room.
// Reset clears phase, carry and line count; groups_per_line returns to 19.
// A stalled output fills the queue and then drops in_ready_o.
module base64_mime_encoder_unit import bme_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  // Front: tracks group phase, builds the character job for each byte.
  logic push;
  logic full;
  job_t job_in;
  // Back: serializes jobs one character per transaction.
  logic pop;
  logic empty;
  job_t job_out;

  bme_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  // Short queue decouples byte intake from character output.
  bme_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .job_o  (job_out)
  );

  bme_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .job_i      (job_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

/* sv/bme_front.sv */
module bme_front import bme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       push_o,
  output job_t       job_o,
  input  logic       full_i
);

  phase_e     phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic [5:0] lcount_q, lcount_d;
  logic [5:0] gpl_q;
  logic [5:0] lcount_inc;
  logic       brk;
  logic [7:0] b;
  logic       last;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign b          = in_item_i.data_byte;
  assign last       = in_item_i.final_byte;
  assign lcount_inc = lcount_q + 6'd1;
  assign brk        = (gpl_q != 6'd0) && (lcount_inc >= gpl_q);

  always_comb begin
    phase_d         = phase_q;
    carry_d         = carry_q;
    lcount_d        = lcount_q;
    job_o.chars     = '0;
    job_o.last_idx  = 2'd0;
    job_o.eot       = last;
    case (phase_q)
      PH_1: begin
        job_o.chars[0] = b64_char({carry_q[1:0], b[7:4]});
        carry_d        = b[3:0];
        phase_d        = PH_2;
        if (last) begin
          job_o.chars[1] = b64_char({b[3:0], 2'b00});
          job_o.chars[2] = CharPad;
          job_o.last_idx = 2'd2;
        end
      end
      PH_2: begin
        job_o.chars[0] = b64_char({carry_q, b[7:6]});
        job_o.chars[1] = b64_char(b[5:0]);
        job_o.last_idx = 2'd1;
        carry_d        = 4'd0;
        phase_d        = PH_0;
        lcount_d       = lcount_inc;
        if (brk) begin
          job_o.chars[2] = CharCr;
          job_o.chars[3] = CharLf;
          job_o.last_idx = 2'd3;
          lcount_d       = 6'd0;
        end
      end
      default: begin
        job_o.chars[0] = b64_char(b[7:2]);
        carry_d        = {2'b00, b[1:0]};
        phase_d        = PH_1;
        if (last) begin
          job_o.chars[1] = b64_char({b[1:0], 4'b0000});
          job_o.chars[2] = CharPad;
          job_o.chars[3] = CharPad;
          job_o.last_idx = 2'd3;
        end
      end
    endcase
    if (last) begin
      phase_d  = PH_0;
      carry_d  = 4'd0;
      lcount_d = 6'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_0;
      carry_q  <= 4'd0;
      lcount_q <= 6'd0;
      gpl_q    <= GroupsPerLineReset;
    end else begin
      if (push_o) begin
        phase_q  <= phase_d;
        carry_q  <= carry_d;
        lcount_q <= lcount_d;
      end
      if (cfg_we_i) begin
        gpl_q <= cfg_wdata_i;
      end
    end
  end

endmodule

/* sv/bme_queue.sv */
module bme_queue import bme_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* sv/bme_back.sv */
module bme_back import bme_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic       valid_q;
  out_item_t  item_q;
  logic [1:0] idx_q;
  logic       load;
  logic       at_end;

  assign load        = !empty_i && (!valid_q || out_ready_i);
  assign at_end      = (idx_q == job_i.last_idx);
  assign pop_o       = load && at_end;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.out_char    <= job_i.chars[idx_q];
      item_q.end_of_text <= job_i.eot && at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule
